// ----- hdl/rdbl_pkg.sv -----
// Package for the record database lexer: lexer state codes, context and token
// types, and the character class helpers. No dependencies.
package rdbl_pkg;

  typedef enum logic [3:0] {
    ST_HEADER  = 4'd0,
    ST_TYPE    = 4'd1,
    ST_VALUE   = 4'd2,
    ST_LPAREN  = 4'd3,
    ST_RPAREN  = 4'd4,
    ST_LCURLY  = 4'd5,
    ST_RCURLY  = 4'd6,
    ST_COMMA   = 4'd7,
    ST_QUOTE   = 4'd8,
    ST_NEWLINE = 4'd9,
    ST_AT      = 4'd10,
    ST_POUND   = 4'd11,
    ST_COMMENT = 4'd12,
    ST_START   = 4'd13,
    ST_INVALID = 4'd14
  } lex_st_t;

  localparam logic [2:0] CALC_FULL = 3'd4;
  localparam logic [2:0] CALC_MISS = 3'd5;

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_QUOTE = 8'h22;

  // Lexer context that moves between the two lex passes of one word.
  typedef struct packed {
    lex_st_t    lex;
    logic       eq;    // equation mode
    logic       cmt;   // comment mode
    logic [2:0] calc;  // CALC characters matched, CALC_MISS on mismatch
  } lex_ctx_t;

  typedef struct packed {
    logic       vld;
    logic [7:0] ch;
    logic [3:0] cls;
    logic       fin;   // token end
  } tok_t;

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_alnum(input logic [7:0] c);
    return is_alpha(c) || is_digit(c);
  endfunction

  function automatic logic is_word(input logic [7:0] c);
    return is_alnum(c) || c == "_";
  endfunction

  function automatic logic is_math(input logic [7:0] c);
    return c == "(" || c == ")" || c == "e" || c == "-" || c == "+" || c == "*" ||
           c == "/" || c == "%" || c == "^" || c == ">" || c == "<" || c == "=" ||
           c == "&" || c == "|" || c == "!" || c == "~" || c == "?" || c == ":" ||
           c == "." || c == "," || c == CH_SPACE;
  endfunction

  function automatic logic [7:0] calc_char(input logic [2:0] idx);
    logic [7:0] r;
    case (idx)
      3'd0:    r = "C";
      3'd1:    r = "A";
      3'd2:    r = "L";
      3'd3:    r = "C";
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic lex_st_t classify_next(input lex_st_t st, input logic [7:0] c);
    lex_st_t r;
    case (c)
      "(":      r = ST_LPAREN;
      ")":      r = ST_RPAREN;
      "{":      r = ST_LCURLY;
      "}":      r = ST_RCURLY;
      ",":      r = ST_COMMA;
      CH_QUOTE: r = ST_QUOTE;
      CH_NL:    r = ST_NEWLINE;
      "@":      r = ST_AT;
      "#":      r = ST_POUND;
      default:  r = (st != ST_VALUE && st != ST_COMMENT) ? ST_INVALID : st;
    endcase
    return r;
  endfunction

  // State after a single-character token.
  function automatic lex_st_t single_next(input lex_st_t st, input logic [7:0] curr,
                                          input logic [7:0] nxt);
    lex_st_t r;
    if (st == ST_POUND) begin
      r = (nxt == CH_NL) ? ST_NEWLINE : ST_COMMENT;
    end else if (st == ST_AT) begin
      r = is_word(nxt) ? ST_VALUE : classify_next(st, nxt);
    end else if (is_alpha(nxt) || nxt == "_") begin
      r = (curr == "(") ? ST_TYPE :
          (curr == "," || curr == CH_QUOTE) ? ST_VALUE : ST_HEADER;
    end else if (is_digit(nxt) || nxt == ".") begin
      r = ST_VALUE;
    end else begin
      r = classify_next(st, nxt);
    end
    return r;
  endfunction

endpackage

// ----- hdl/rdbl_lex.sv -----
// One lex step: classifies the held character against its lookahead.
// Combinational; depends on rdbl_pkg.
module rdbl_lex #(
  parameter int LINE_BITS = 16
) (
  input  rdbl_pkg::lex_ctx_t   ctx_i,
  input  logic [LINE_BITS-1:0] line_i,
  input  logic [7:0]           curr_i,
  input  logic [7:0]           next_i,
  output rdbl_pkg::lex_ctx_t   ctx_o,
  output logic [LINE_BITS-1:0] line_o,
  output rdbl_pkg::tok_t       tok_o
);
  import rdbl_pkg::*;

  localparam logic [LINE_BITS-1:0] LineMax = {LINE_BITS{1'b1}};

  lex_st_t nl;

  assign nl = classify_next(ctx_i.lex, next_i);

  always_comb begin
    ctx_o     = ctx_i;
    line_o    = line_i;
    tok_o.vld = 1'b0;
    tok_o.ch  = curr_i;
    tok_o.cls = ctx_i.lex;
    tok_o.fin = 1'b0;
    case (ctx_i.lex)
      ST_HEADER: begin
        tok_o.vld = 1'b1;
        if (!is_word(next_i) && next_i != ":" && !ctx_i.cmt) begin
          ctx_o.lex = nl;
          if (nl != ctx_i.lex) begin
            ctx_o.calc = '0;
            tok_o.fin  = 1'b1;
          end
        end
      end
      ST_TYPE: begin
        tok_o.vld = 1'b1;
        if (ctx_i.calc < CALC_FULL && curr_i == calc_char(ctx_i.calc)) begin
          ctx_o.calc = ctx_i.calc + 3'd1;
        end else begin
          ctx_o.calc = CALC_MISS;
        end
        if (!is_word(next_i) && !ctx_i.cmt) begin
          ctx_o.eq  = (ctx_o.calc == CALC_FULL);
          ctx_o.lex = nl;
          if (nl != ctx_i.lex) begin
            ctx_o.calc = '0;
            tok_o.fin  = 1'b1;
          end
        end
      end
      ST_VALUE: begin
        tok_o.vld = 1'b1;
        if (ctx_i.eq) begin
          if (next_i == CH_NL ||
              (!is_alnum(next_i) && next_i != ":" && !is_math(next_i))) begin
            ctx_o.eq  = 1'b0;
            ctx_o.lex = nl;
            if (nl != ctx_i.lex) begin
              ctx_o.calc = '0;
              tok_o.fin  = 1'b1;
            end
          end
        end else if (!is_alnum(next_i) && next_i != "-" && next_i != "_" &&
                     next_i != "." && next_i != "e" && next_i != "E" && !ctx_i.cmt) begin
          ctx_o.lex = nl;
          if (nl != ctx_i.lex) begin
            ctx_o.calc = '0;
            tok_o.fin  = 1'b1;
          end
        end
      end
      ST_LPAREN, ST_RPAREN, ST_LCURLY, ST_RCURLY: begin
        if (!ctx_i.eq) begin
          tok_o.vld = 1'b1;
          tok_o.fin = 1'b1;
          ctx_o.lex = single_next(ctx_i.lex, curr_i, next_i);
        end else begin
          // brackets inside an equation are swallowed
          ctx_o.lex = ST_VALUE;
        end
      end
      ST_COMMA: begin
        tok_o.vld = 1'b1;
        tok_o.fin = 1'b1;
        ctx_o.lex = single_next(ctx_i.lex, curr_i, next_i);
      end
      ST_QUOTE: begin
        tok_o.vld = 1'b1;
        tok_o.fin = 1'b1;
        ctx_o.lex = ctx_i.eq ? ST_VALUE : single_next(ctx_i.lex, curr_i, next_i);
      end
      ST_NEWLINE: begin
        tok_o.vld = 1'b1;
        tok_o.fin = 1'b1;
        ctx_o.eq  = 1'b0;
        ctx_o.cmt = 1'b0;
        ctx_o.lex = single_next(ctx_i.lex, curr_i, next_i);
        if (line_i != LineMax) begin
          line_o = line_i + 1'b1;
        end
      end
      ST_AT: begin
        tok_o.vld = 1'b1;
        tok_o.fin = 1'b1;
        ctx_o.eq  = 1'b1;
        ctx_o.lex = single_next(ctx_i.lex, curr_i, next_i);
      end
      ST_POUND: begin
        tok_o.vld = 1'b1;
        tok_o.fin = 1'b1;
        ctx_o.cmt = 1'b1;
        ctx_o.lex = single_next(ctx_i.lex, curr_i, next_i);
      end
      ST_COMMENT: begin
        tok_o.vld = 1'b1;
        if (next_i == CH_NL) begin
          ctx_o.lex = nl;
          if (nl != ctx_i.lex) begin
            ctx_o.calc = '0;
            tok_o.fin  = 1'b1;
          end
        end
      end
      default: begin
        // start and invalid: nothing is sent
      end
    endcase
  end

endmodule

// ----- hdl/record_db_lexer.sv -----
// Top level of the record database lexer: byte filter, two chained lex steps
// and a three-word result queue. Depends on rdbl_pkg and rdbl_lex.
// Usage:
//   in_*  : one text byte per word (in_tdata), in_tlast on the final byte.
//   out_* : one token character per word, with its class and token end mark
//           in out_tuser and its line number in out_tdata; out_tlast flags the
//           last character of the stream.
//   Tabs and CRs are dropped, spaces are dropped outside double quotes. The
//   lexer runs one character behind the input (lookahead of one), so a byte
//   normally yields the previous character; the final byte also flushes the
//   held one, giving up to two words for that input word.
// Results are registered in the queue and reach out_* from its head.
// Throughput: one input word per cycle while the receiver keeps up; a byte
//   that yields two words enters the queue together and leaves it one word at
//   a time. Rate is set by the single output port draining a three-entry queue.
// Reset (rst_n low, synchronous): lexer returns to its start state, line count
//   to 1, queue empties. The same per-stream state is restored after the word
//   carrying in_tlast.
// Stall: with out_tready low, results wait in the queue; input is still taken
//   while at least two entries are free (or one frees this cycle).
module record_db_lexer #(
  parameter int LINE_BITS = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_tvalid,
  output logic                    in_tready,
  input  logic [7:0]              in_tdata,   // [7:0] in_char
  input  logic                    in_tlast,   // in_last
  output logic                    out_tvalid,
  input  logic                    out_tready,
  output logic [((8+LINE_BITS+7)/8)*8-1:0] out_tdata, // out_char, line_no, zero pad
  output logic [4:0]              out_tuser,  // [3:0] token_class, [4] token_end
  output logic                    out_tlast   // stream_end
);
  import rdbl_pkg::*;

  localparam int DataW = ((8 + LINE_BITS + 7) / 8) * 8;
  localparam int PadW  = DataW - 8 - LINE_BITS;
  localparam int QDepth = 3;
  localparam logic [LINE_BITS-1:0] LineOne = {{(LINE_BITS-1){1'b0}}, 1'b1};

  typedef struct packed {
    logic [7:0] ch;
    logic [3:0] cls;
    logic       fin;
    logic       send;
  } q_ent_t;

  localparam lex_ctx_t CtxReset = '{lex: ST_START, eq: 1'b0, cmt: 1'b0, calc: 3'd0};

  // stream state
  lex_ctx_t             ctx_r, ctx_nxt;
  logic [LINE_BITS-1:0] line_r, line_nxt;
  logic                 iq_r, iq_nxt;        // inside quotes
  logic                 hv_r, hv_nxt;        // held char valid
  logic [7:0]           held_r, held_nxt;

  // result queue, head at entry 0
  q_ent_t               q_r [QDepth];
  q_ent_t               q_nxt [QDepth];
  logic [LINE_BITS-1:0] ql_r [QDepth];
  logic [LINE_BITS-1:0] ql_nxt [QDepth];
  logic [1:0]           cnt_r, cnt_nxt;

  logic push, pop, keep, last;
  logic [7:0] c;

  // lex pass A: held char against the incoming byte
  lex_ctx_t             ctx_a;
  logic [LINE_BITS-1:0] line_a;
  tok_t                 tok_a;
  // lex pass B: flush at end of stream against a trailing space
  lex_ctx_t             ctx1, ctx_b;
  logic [LINE_BITS-1:0] line1, line_b;
  tok_t                 tok_b;
  logic                 hv1;
  logic [7:0]           held1;
  logic                 use_a, use_b, va, vb;

  assign c    = in_tdata;
  assign last = in_tlast;
  assign pop  = out_tvalid && out_tready;
  assign in_tready = (cnt_r <= 2'd1) || (cnt_r == 2'd2 && out_tready);
  assign push = in_tvalid && in_tready;

  // byte filter and quote toggle
  always_comb begin
    keep   = 1'b1;
    iq_nxt = iq_r;
    if (c == CH_TAB || c == CH_CR) begin
      keep = 1'b0;
    end else if (c == CH_QUOTE) begin
      iq_nxt = !iq_r;
    end else if (c == CH_SPACE && !iq_r) begin
      keep = 1'b0;
    end
  end

  assign use_a = keep && hv_r;

  rdbl_lex #(.LINE_BITS(LINE_BITS)) u_lex_a (
    .ctx_i  (ctx_r),
    .line_i (line_r),
    .curr_i (held_r),
    .next_i (c),
    .ctx_o  (ctx_a),
    .line_o (line_a),
    .tok_o  (tok_a)
  );

  always_comb begin
    ctx1  = ctx_r;
    line1 = line_r;
    if (use_a) begin
      ctx1  = ctx_a;
      line1 = line_a;
    end else if (keep) begin
      // first kept char of a stream picks the opening state
      ctx1.lex = is_word(c) ? ST_HEADER : classify_next(ST_START, c);
    end
  end

  assign hv1   = hv_r || keep;
  assign held1 = keep ? c : held_r;
  assign use_b = last && hv1;

  rdbl_lex #(.LINE_BITS(LINE_BITS)) u_lex_b (
    .ctx_i  (ctx1),
    .line_i (line1),
    .curr_i (held1),
    .next_i (CH_SPACE),
    .ctx_o  (ctx_b),
    .line_o (line_b),
    .tok_o  (tok_b)
  );

  assign va = use_a && tok_a.vld;
  assign vb = use_b && tok_b.vld;

  // next stream state
  always_comb begin
    held_nxt = held1;
    if (last) begin
      ctx_nxt  = CtxReset;
      line_nxt = LineOne;
      hv_nxt   = 1'b0;
    end else begin
      ctx_nxt  = ctx1;
      line_nxt = line1;
      hv_nxt   = hv1;
    end
  end

  // queue update: pop first, then append up to two results
  always_comb begin
    logic [1:0] wr;
    wr = cnt_r;
    for (int i = 0; i < QDepth; i++) begin
      q_nxt[i]  = q_r[i];
      ql_nxt[i] = ql_r[i];
    end
    if (pop) begin
      for (int i = 0; i < QDepth - 1; i++) begin
        q_nxt[i]  = q_r[i+1];
        ql_nxt[i] = ql_r[i+1];
      end
      wr = cnt_r - 2'd1;
    end
    if (push && va) begin
      if (wr < 2'(QDepth)) begin
        q_nxt[wr[1:0]]  = '{ch: tok_a.ch, cls: tok_a.cls, fin: tok_a.fin,
                           send: last && !vb};
        ql_nxt[wr[1:0]] = line_r;
      end
      wr = wr + 2'd1;
    end
    if (push && vb) begin
      if (wr < 2'(QDepth)) begin
        q_nxt[wr[1:0]]  = '{ch: tok_b.ch, cls: tok_b.cls, fin: tok_b.fin, send: 1'b1};
        ql_nxt[wr[1:0]] = line1;
      end
      wr = wr + 2'd1;
    end
    cnt_nxt = wr;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctx_r  <= CtxReset;
      line_r <= LineOne;
      iq_r   <= 1'b0;
      hv_r   <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        ctx_r  <= ctx_nxt;
        line_r <= line_nxt;
        iq_r   <= last ? 1'b0 : iq_nxt;
        hv_r   <= hv_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      held_r <= held_nxt;
    end
    for (int i = 0; i < QDepth; i++) begin
      q_r[i]  <= q_nxt[i];
      ql_r[i] <= ql_nxt[i];
    end
  end

  assign out_tvalid = (cnt_r != 2'd0);
  assign out_tdata  = {{PadW{1'b0}}, ql_r[0], q_r[0].ch};
  assign out_tuser  = {q_r[0].fin, q_r[0].cls};
  assign out_tlast  = q_r[0].send;

endmodule
